// ===== rtl/ed3s_pkg.sv =====
`default_nettype none

package ed3s_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int HREG_W      = 12;
  localparam int BPPREG_W    = 3;
  localparam int ROW_W       = 12;
  localparam int RESP_W      = 13;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_BPP   = 4;
  localparam int MAX_HEIGHT    = 2048;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH     = 12'd512;
  localparam logic [HREG_W-1:0]     RST_IMAGE_HEIGHT    = 12'd512;
  localparam logic [BPPREG_W-1:0]   RST_BYTES_PER_PIXEL = 3'd3;

  localparam logic OP_IMAGE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;
  localparam int MAG_LIMIT = 127;

  typedef struct packed {
    logic img;
    logic emit;
    logic interior;
    logic last;
  } s1_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/edge_detect_3x3_stream_unit.sv =====
// Streaming 3x3 Laplacian edge filter for channel-interleaved raster images.
// The input channel (in_valid/in_ready) takes one request per cycle unless
// stalled: an image byte (in_op clear) or a drain tick (in_op set) after the
// frame's last byte. The output channel (out_valid/out_ready) gives one
// filtered byte for each raster position, lagging the input by one line plus
// one pixel; borders give zero and out_frame_end marks the frame's final byte.
// A request is loaded into the result stage (line store reads and frame
// counters) at acceptance; its result then moves on to the output register,
// which drives out_valid. One request per cycle is sustained while out_ready
// is high; each image byte makes one read and one write per line store.
// The configuration port (cfg_we/cfg_index/cfg_data) writes image_width,
// image_height and bytes_per_pixel; each write to them restarts the frame.
// Writes are to be made only while the block is idle; it does not enforce this.
// Synchronous reset (rst_n low) restores the default 512 x 512 x 3 format
// and clears all frame counters; the line stores need no clearing pass.
// When the receiver stalls, the output register holds its byte, the result
// stage fills, and in_ready drops until out_ready returns.
`default_nettype none

module edge_detect_3x3_stream_unit
  import ed3s_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_BPP   = DEF_MAX_BPP
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_op,
  input  wire logic [PIX_W-1:0]       in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PIX_W-1:0]            out_edge_value,
  output logic                        out_frame_end
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int STRIDE_W   = $clog2(LINE_DEPTH + 1);
  localparam int SUM_W      = STRIDE_W + 1;
  localparam int W_W        = $clog2(MAX_WIDTH + 1);
  localparam int B_W        = $clog2(MAX_BPP + 1);

  logic [CFG_DATA_W-1:0] image_width_r;
  logic [HREG_W-1:0]     image_height_r;
  logic [BPPREG_W-1:0]   bytes_per_pixel_r;

  logic [W_W-1:0]      w_eff;
  logic [HREG_W-1:0]   h_eff;
  logic [B_W-1:0]      bpp;
  logic [STRIDE_W-1:0] stride;
  logic [STRIDE_W-1:0] bpp_ext;

  logic [ADDR_W-1:0] in_column_r, in_column_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [ADDR_W-1:0] out_column_r, out_column_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              input_done_r, input_done_nxt;

  logic       in_fire;
  logic       cfg_hit;
  logic       s0_img;
  logic       s0_emit;
  logic       s0_interior;
  logic       s0_last;
  logic [STRIDE_W-1:0] col_ext;
  logic [STRIDE_W-1:0] ocol_ext;
  logic [ROW_W-1:0]    orow_adv;

  logic              s1_valid_r, s1_valid_nxt;
  s1_ctrl_t          s1_ctrl_r, s1_ctrl_nxt;
  logic [PIX_W-1:0]  s1_sample_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic              s1_fire;

  logic [PIX_W-1:0] middle_mem [LINE_DEPTH];
  logic [PIX_W-1:0] upper_mem [LINE_DEPTH];
  logic [PIX_W-1:0] mid_rd_r;
  logic [PIX_W-1:0] up_rd_r;
  logic             up_fwd_r;
  logic [PIX_W-1:0] up_fwd_data_r;
  logic [PIX_W-1:0] mid_eff;
  logic [PIX_W-1:0] up_eff;

  logic [PIX_W-1:0] row_in [3];
  logic [PIX_W-1:0] sh_a_r [3][MAX_BPP];
  logic [PIX_W-1:0] sh_b_r [3][MAX_BPP];

  logic [RESP_W-1:0]        pos_sum;
  logic [RESP_W-1:0]        neg_sum;
  logic signed [RESP_W-1:0] resp;
  logic [RESP_W-1:0]        mag;
  logic [PIX_W-1:0]         s1_value;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_edge_value_r;
  logic             out_frame_end_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= RST_IMAGE_WIDTH;
      image_height_r    <= RST_IMAGE_HEIGHT;
      bytes_per_pixel_r <= RST_BYTES_PER_PIXEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     image_width_r <= cfg_data;
        REG_IMAGE_HEIGHT:    image_height_r <= cfg_data[HREG_W-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel_r <= cfg_data[BPPREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                              (cfg_index == REG_IMAGE_HEIGHT) ||
                              (cfg_index == REG_BYTES_PER_PIXEL));

  // Out-of-range register values are used as the nearest legal value.
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = W_W'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = HREG_W'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      h_eff = HREG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    if (bytes_per_pixel_r == '0) begin
      bpp = B_W'(1);
    end else if (32'(bytes_per_pixel_r) > MAX_BPP) begin
      bpp = B_W'(MAX_BPP);
    end else begin
      bpp = B_W'(bytes_per_pixel_r);
    end
  end

  assign bpp_ext = STRIDE_W'(bpp);
  assign stride  = STRIDE_W'(w_eff) * bpp_ext;

  // Handshake between the input stage, the result stage and the output register.
  assign s1_fire  = s1_valid_r && (!s1_ctrl_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Frame position counters.
  always_comb begin
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    input_done_nxt = input_done_r;
    s0_img         = 1'b0;
    s0_emit        = 1'b0;
    s0_interior    = 1'b0;
    s0_last        = 1'b0;
    col_ext        = STRIDE_W'(in_column_r);
    ocol_ext       = STRIDE_W'(out_column_r);
    orow_adv       = out_row_r;

    if (in_fire) begin
      if (in_op == OP_DRAIN) begin
        s0_emit = input_done_r;
      end else if (!input_done_r) begin
        s0_img  = 1'b1;
        s0_emit = (in_row_r > ROW_W'(1)) ||
                  ((in_row_r == ROW_W'(1)) && (col_ext >= bpp_ext));
        if (col_ext + STRIDE_W'(1) >= stride) begin
          in_column_nxt = '0;
          in_row_nxt    = in_row_r + ROW_W'(1);
          if (in_row_r + ROW_W'(1) >= h_eff) begin
            input_done_nxt = 1'b1;
          end
        end else begin
          in_column_nxt = in_column_r + ADDR_W'(1);
        end
      end

      if (s0_emit) begin
        s0_interior = s0_img && (out_row_r >= ROW_W'(1)) &&
                      (out_row_r + ROW_W'(1) < h_eff) &&
                      (ocol_ext >= bpp_ext) &&
                      (SUM_W'(ocol_ext) + SUM_W'(bpp_ext) < SUM_W'(stride));
        if (ocol_ext + STRIDE_W'(1) >= stride) begin
          out_column_nxt = '0;
          orow_adv       = out_row_r + ROW_W'(1);
        end else begin
          out_column_nxt = out_column_r + ADDR_W'(1);
        end
        out_row_nxt = orow_adv;
        s0_last     = (orow_adv >= h_eff);
        if (s0_last) begin
          in_column_nxt  = '0;
          in_row_nxt     = '0;
          out_column_nxt = '0;
          out_row_nxt    = '0;
          input_done_nxt = 1'b0;
        end
      end
    end

    if (cfg_hit) begin
      in_column_nxt  = '0;
      in_row_nxt     = '0;
      out_column_nxt = '0;
      out_row_nxt    = '0;
      input_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
      input_done_r <= 1'b0;
    end else begin
      in_column_r  <= in_column_nxt;
      in_row_r     <= in_row_nxt;
      out_column_r <= out_column_nxt;
      out_row_r    <= out_row_nxt;
      input_done_r <= input_done_nxt;
    end
  end

  // Result stage control.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ctrl_nxt  = s1_ctrl_r;
    if (in_fire) begin
      s1_valid_nxt         = s0_img || s0_emit;
      s1_ctrl_nxt.img      = s0_img;
      s1_ctrl_nxt.emit     = s0_emit;
      s1_ctrl_nxt.interior = s0_interior;
      s1_ctrl_nxt.last     = s0_last;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_ctrl_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_ctrl_r  <= s1_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= in_column_r;
    end
  end

  // The middle line is read and rewritten with each image byte at acceptance.
  always_ff @(posedge clk) begin
    if (s0_img) begin
      mid_rd_r                <= middle_mem[in_column_r];
      middle_mem[in_column_r] <= in_sample;
    end
  end

  // The upper line takes the old middle byte when the result stage fires, so
  // a read of the column written in the same cycle is served from the bypass.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.img) begin
      upper_mem[s1_col_r] <= mid_eff;
    end
    if (s0_img) begin
      up_rd_r <= upper_mem[in_column_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s0_img) begin
      up_fwd_r      <= s1_fire && s1_ctrl_r.img && (s1_col_r == in_column_r);
      up_fwd_data_r <= mid_eff;
    end
  end

  assign mid_eff = mid_rd_r;
  assign up_eff  = up_fwd_r ? up_fwd_data_r : up_rd_r;

  assign row_in[0] = up_eff;
  assign row_in[1] = mid_eff;
  assign row_in[2] = s1_sample_r;

  // Per window row, two delay lines of bpp bytes give the same channel's
  // bytes one and two pixels back at their first tap.
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar i = 0; i < MAX_BPP; i++) begin : g_tap
      always_ff @(posedge clk) begin
        if (s1_fire && s1_ctrl_r.img) begin
          if (bpp == B_W'(i + 1)) begin
            sh_a_r[r][i] <= row_in[r];
            sh_b_r[r][i] <= sh_a_r[r][0];
          end else begin
            if (i < MAX_BPP - 1) begin
              sh_a_r[r][i] <= sh_a_r[r][(i + 1) % MAX_BPP];
              sh_b_r[r][i] <= sh_b_r[r][(i + 1) % MAX_BPP];
            end
          end
        end
      end
    end
  end

  // Kernel: 4 * center - 2 * edges + corners, then min(2 * |response|, 255).
  always_comb begin
    pos_sum = (RESP_W'(sh_a_r[1][0]) << 2) +
              RESP_W'(sh_b_r[0][0]) + RESP_W'(up_eff) +
              RESP_W'(sh_b_r[2][0]) + RESP_W'(s1_sample_r);
    neg_sum = (RESP_W'(sh_a_r[0][0]) + RESP_W'(sh_b_r[1][0]) +
               RESP_W'(mid_eff) + RESP_W'(sh_a_r[2][0])) << 1;
    resp    = $signed(pos_sum - neg_sum);
    mag     = resp[RESP_W-1] ? RESP_W'(-resp) : RESP_W'(resp);
    if (!s1_ctrl_r.interior) begin
      s1_value = '0;
    end else if (mag > RESP_W'(MAG_LIMIT)) begin
      s1_value = PIX_MAX;
    end else begin
      s1_value = {mag[PIX_W-2:0], 1'b0};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_ctrl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.emit) begin
      out_edge_value_r <= s1_value;
      out_frame_end_r  <= s1_ctrl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_value_r;
  assign out_frame_end  = out_frame_end_r;

`ifndef SYNTHESIS
  a_frame_end_is_border : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_edge_value == '0)
    else $error("frame end byte is not a border zero");

  a_done_at_row_start : assert property (@(posedge clk) disable iff (!rst_n)
    input_done_r |-> in_column_r == '0)
    else $error("input complete in the middle of a row");

  a_interior_from_image : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_ctrl_r.interior |-> s1_ctrl_r.img && s1_ctrl_r.emit)
    else $error("interior result without an image byte");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_ctrl_r))
    else $error("result stage changed while stalled");
`endif

endmodule

`default_nettype wire
